// File: design/speed_ramp_with_overcurrent_trip_defines.svh
// Assertion macros used by the speed ramp top level.
// Each macro expects signals named clock and reset in the including scope.
`ifndef SPEED_RAMP_WITH_OVERCURRENT_TRIP_DEFINES_SVH
`define SPEED_RAMP_WITH_OVERCURRENT_TRIP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SROT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SROT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/srot_pkg.sv
// Types, codes, reset values and helper functions for the speed ramp block.
// No dependencies; imported by every module of the block.
package srot_pkg;

   localparam int SPD_W = 12;
   localparam int REQ_SPEED_W = 11;
   localparam int THRESH_W = 12;
   localparam int BLANK_W = 16;
   localparam int PERIOD_W = 8;
   localparam int DAC_W = 8;
   localparam int OUT_SPEED_W = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);
   localparam logic [BLANK_W-1:0] BLANK_RESET = BLANK_W'(5000);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);
   localparam logic [DAC_W-1:0] DAC_FULL = '1;
   localparam logic [BLANK_W-1:0] UPTIME_FULL = '1;

   typedef logic signed [SPD_W-1:0] speed_type;

   typedef enum logic [2:0] {
      OP_TICK = 3'd0,
      OP_SET_TARGET = 3'd1,
      OP_REVERSE = 3'd2,
      OP_STOP = 3'd3,
      OP_CLEAR_FAULT = 3'd4
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIP_THRESHOLD = 2'd0,
      CSR_BLANKING_TICKS = 2'd1,
      CSR_RAMP_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0] trip_threshold;
      logic [BLANK_W-1:0] blanking_ticks;
      logic [PERIOD_W-1:0] ramp_period;
   } cfg_type;

   typedef struct packed {
      speed_type speed_now;
      speed_type speed_goal;
      logic relay_state;
      logic [DAC_W-1:0] dac_state;
      logic supply_on;
      logic [BLANK_W-1:0] uptime_count;
      logic [PERIOD_W-1:0] ramp_divider;
   } state_type;

   typedef struct packed {
      opcode_type opcode;
      logic signed [REQ_SPEED_W-1:0] speed_value;
      logic reverse_flag;
   } item_type;

   // Packed so that the first field sits in the highest bits.
   typedef struct packed {
      logic fault_tripped;
      logic command_rejected;
      logic enabled;
      logic signed [OUT_SPEED_W-1:0] target_speed;
      logic signed [OUT_SPEED_W-1:0] actual_speed;
      logic relay_drive;
      logic [DAC_W-1:0] dac_level;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   function automatic speed_type magnitude(input speed_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [DAC_W-1:0] dac_of(input speed_type v);
      speed_type m;
      m = magnitude(v);
      return (m > speed_type'(DAC_FULL)) ? DAC_FULL : m[DAC_W-1:0];
   endfunction

endpackage

// File: design/srot_csr.sv
// Configuration registers of the speed ramp block.
// Depends on srot_pkg for the register layout, indexes and reset values.
module srot_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [srot_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srot_pkg::BLANK_W-1:0] csr_data,
   output srot_pkg::cfg_type cfg
);
   import srot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIP_THRESHOLD: cfg_in.trip_threshold = csr_data[THRESH_W-1:0];
            CSR_BLANKING_TICKS: cfg_in.blanking_ticks = csr_data[BLANK_W-1:0];
            CSR_RAMP_PERIOD: cfg_in.ramp_period = csr_data[PERIOD_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_threshold <= THRESH_RESET;
         cfg_ff.blanking_ticks <= BLANK_RESET;
         cfg_ff.ramp_period <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/srot_step.sv
// Next-state and result logic for one transaction of the speed ramp block.
// Depends on srot_pkg for the state, item, configuration and result types.
module srot_step #(
   parameter int SPEED_MAX = 255,
   parameter int SENSE_BITS = 12
) (
   input  srot_pkg::state_type state,
   input  srot_pkg::cfg_type cfg,
   input  srot_pkg::item_type item,
   input  logic [SENSE_BITS-1:0] sense_sample,
   output srot_pkg::state_type state_next,
   output srot_pkg::result_type result
);
   import srot_pkg::*;

   localparam int CMP_W = (SENSE_BITS > THRESH_W) ? SENSE_BITS : THRESH_W;
   localparam int LIM_W = 14;
   localparam logic signed [LIM_W-1:0] LIMIT_HI = LIM_W'(SPEED_MAX);
   localparam logic signed [LIM_W-1:0] LIMIT_LO = -LIM_W'(SPEED_MAX);

   always_comb begin
      state_type s;
      logic rejected;
      logic tripped;
      logic [PERIOD_W-1:0] div_inc;
      logic signed [LIM_W-1:0] req_wide;

      s = state;
      rejected = 1'b0;
      tripped = 1'b0;
      div_inc = state.ramp_divider + PERIOD_W'(1);
      req_wide = LIM_W'(item.speed_value);

      unique case (item.opcode)
         OP_TICK: begin
            if (s.uptime_count != UPTIME_FULL) begin
               s.uptime_count = s.uptime_count + BLANK_W'(1);
            end
            if ((s.uptime_count > cfg.blanking_ticks) &&
                (CMP_W'(sense_sample) > CMP_W'(cfg.trip_threshold))) begin
               s.dac_state = '0;
               s.speed_now = '0;
               s.speed_goal = '0;
               s.relay_state = 1'b1;
               s.supply_on = 1'b0;
               tripped = 1'b1;
            end
            if (div_inc >= cfg.ramp_period) begin
               s.ramp_divider = '0;
               if (s.supply_on && (s.speed_now != s.speed_goal)) begin
                  if (s.speed_now > s.speed_goal) begin
                     s.speed_now = s.speed_now - speed_type'(1);
                  end else begin
                     s.speed_now = s.speed_now + speed_type'(1);
                  end
                  s.relay_state = ~s.speed_now[SPD_W-1];
                  s.dac_state = dac_of(s.speed_now);
               end
            end else begin
               s.ramp_divider = div_inc;
            end
         end
         OP_SET_TARGET: begin
            if (s.supply_on && (req_wide <= LIMIT_HI) && (req_wide >= LIMIT_LO)) begin
               s.speed_goal = SPD_W'(item.speed_value);
            end else begin
               rejected = 1'b1;
            end
         end
         OP_REVERSE: begin
            s.relay_state = ~item.reverse_flag;
            if (item.reverse_flag) begin
               s.speed_now = -magnitude(s.speed_now);
               s.speed_goal = -magnitude(s.speed_goal);
            end else begin
               s.speed_now = magnitude(s.speed_now);
               s.speed_goal = magnitude(s.speed_goal);
            end
         end
         OP_STOP: begin
            s.dac_state = '0;
            s.speed_now = '0;
            s.speed_goal = '0;
            s.relay_state = 1'b1;
         end
         OP_CLEAR_FAULT: begin
            s.supply_on = 1'b1;
         end
         default: begin
            s = state;
         end
      endcase

      state_next = s;
      result.dac_level = s.dac_state;
      result.relay_drive = s.relay_state;
      result.actual_speed = s.speed_now[OUT_SPEED_W-1:0];
      result.target_speed = s.speed_goal[OUT_SPEED_W-1:0];
      result.enabled = s.supply_on;
      result.command_rejected = rejected;
      result.fault_tripped = tripped;
   end

endmodule

// File: design/speed_ramp_with_overcurrent_trip.sv
// Top level of the signed speed ramp with overcurrent trip.
// Depends on srot_pkg, srot_csr, srot_step and the assertion macro header.
//
// Usage:
//   req channel: one transaction per tick or command. req_tuser carries the opcode,
//   req_tdata the speed value, reverse flag and current-sense sample.
//   rsp channel: exactly one result transaction per request, in order, carrying
//   the converter level, relay, both speeds, enable and the two event flags.
//   csr channel: writes the trip threshold, blanking time and ramp period; it is
//   always ready and should be used only while no request is in flight.
// Path: an accepted request sits in the input register, the step logic writes the
//   result register from it, and the result is held there until the receiver takes it.
// Throughput: one transaction per cycle while rsp_tready stays high; the state registers update
//   once per transaction in a single pass.
// Reset: supply enabled, speeds zero, relay forward, converter level zero, uptime
//   and divider zero, registers at their default values; both channels empty.
// Stall: when rsp_tready is low the result holds and the input register fills;
//   after that req_tready drops until the receiver takes the result.
`include "speed_ramp_with_overcurrent_trip_defines.svh"

module speed_ramp_with_overcurrent_trip #(
   parameter int SPEED_MAX = 255,
   parameter int SENSE_BITS = 12,
   localparam int REQ_DATA_W = ((srot_pkg::REQ_SPEED_W + 1 + SENSE_BITS + 7) / 8) * 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // speed_value[10:0], reverse_flag, sense_sample, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // dac_level[7:0], relay_drive, actual_speed[8:0], target_speed[8:0],
   // enabled, command_rejected, fault_tripped, zero fill
   output logic [31:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [srot_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srot_pkg::BLANK_W-1:0] csr_data
);
   import srot_pkg::*;

   localparam int SAMPLE_LSB = REQ_SPEED_W + 1;

   cfg_type cfg;
   item_type item_ff;
   item_type item_in;
   logic [SENSE_BITS-1:0] sample_ff;
   logic in_valid_ff;
   state_type state_ff;
   state_type state_in;
   result_type result_ff;
   result_type result_in;
   logic out_valid_ff;
   logic step_fire;
   logic dac_matches;
   logic trip_shown;
   logic held_off;

   srot_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   srot_step #(
      .SPEED_MAX(SPEED_MAX),
      .SENSE_BITS(SENSE_BITS)
   ) u_step (
      .state(state_ff),
      .cfg(cfg),
      .item(item_ff),
      .sense_sample(sample_ff),
      .state_next(state_in),
      .result(result_in)
   );

   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;

   assign item_in.opcode = opcode_type'(req_tuser);
   assign item_in.speed_value = req_tdata[REQ_SPEED_W-1:0];
   assign item_in.reverse_flag = req_tdata[REQ_SPEED_W];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {(32 - RESULT_W)'(0), result_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
         sample_ff <= req_tdata[SAMPLE_LSB +: SENSE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.speed_now <= '0;
         state_ff.speed_goal <= '0;
         state_ff.relay_state <= 1'b1;
         state_ff.dac_state <= '0;
         state_ff.supply_on <= 1'b1;
         state_ff.uptime_count <= '0;
         state_ff.ramp_divider <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign dac_matches = (state_ff.dac_state == dac_of(state_ff.speed_now));
   assign trip_shown = !result_ff.enabled && (result_ff.dac_level == '0) &&
      (result_ff.actual_speed == '0);
   assign held_off = step_fire && !state_ff.supply_on && (item_ff.opcode != OP_CLEAR_FAULT);

   `SROT_ASSERT_NOW(a_dac_tracks_speed, 1'b1, dac_matches, "Converter level off speed.")
   `SROT_ASSERT_NOW(a_trip_halts, out_valid_ff && result_ff.fault_tripped, trip_shown, "Trip not halted.")
   `SROT_ASSERT_NOW(a_flags_exclusive, out_valid_ff, !(result_ff.fault_tripped && result_ff.command_rejected), "Two flags.")
   `SROT_ASSERT_NEXT(a_enable_only_by_clear, held_off, !state_ff.supply_on, "Enabled without clear.")
   `SROT_ASSERT_NEXT(a_no_input_overwrite, in_valid_ff && !step_fire, in_valid_ff && $stable(item_ff), "Input lost.")

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the speed ramp with overcurrent trip: directed table, random phases.
// Predicts each result in-line, checks every result transaction, and varies config and idling.
// Depends on srot_pkg and the speed_ramp_with_overcurrent_trip top level.
module tb_top;
   import srot_pkg::*;

   localparam int REQ_DATA_W = ((REQ_SPEED_W + 1 + 12 + 7) / 8) * 8;
   localparam int SPEED_LIMIT = 255;
   localparam int UPTIME_SAT = 65535;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      bit is_csr;
      logic [2:0] op;
      logic signed [REQ_SPEED_W-1:0] speed;
      logic rev;
      logic [11:0] sense;
      bit typed;
      result_type drive;
      csr_index_type reg_index;
      logic [BLANK_W-1:0] reg_value;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BLANK_W-1:0] csr_data = '0;

   speed_ramp_with_overcurrent_trip DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predicted drive state and configuration.
   int speed_now, speed_goal, dac, uptime, ramp_count;
   bit relay, powered;
   int trip_level, blank_len, ramp_len;

   result_type expected_drive[$];
   stim_row_type script[$];
   int send_idle_pct, stall_pct;
   bit req_held, csr_held;
   int fail_count, n_items, n_results, n_trips, n_rejects, n_ramps, cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic result_type drive_result(int dac_v, bit relay_v, int act, int tgt, bit en,
         bit rej, bit trip);
      result_type r;
      r.dac_level = dac_v;
      r.relay_drive = relay_v;
      r.actual_speed = act;
      r.target_speed = tgt;
      r.enabled = en;
      r.command_rejected = rej;
      r.fault_tripped = trip;
      return r;
   endfunction

   function automatic stim_row_type item_row(logic [2:0] op, int speed, logic rev, int sense,
         bit typed, result_type drive);
      stim_row_type row;
      row.is_csr = 1'b0;
      row.op = op;
      row.speed = speed;
      row.rev = rev;
      row.sense = sense;
      row.typed = typed;
      row.drive = drive;
      row.reg_index = CSR_TRIP_THRESHOLD;
      row.reg_value = '0;
      return row;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type idx, int value);
      stim_row_type row;
      row.is_csr = 1'b1;
      row.op = '0;
      row.speed = '0;
      row.rev = 1'b0;
      row.sense = '0;
      row.typed = 1'b0;
      row.drive = '0;
      row.reg_index = idx;
      row.reg_value = value;
      return row;
   endfunction

   function automatic int magnitude_of(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void halt_drive();
      dac = 0;
      speed_now = 0;
      speed_goal = 0;
      relay = 1'b1;
   endfunction

   function automatic result_type predict_drive_result(logic [2:0] op,
         logic signed [REQ_SPEED_W-1:0] speed_req, logic rev, logic [11:0] sense);
      int req;
      bit refused, tripped;
      req = speed_req;
      refused = 1'b0;
      tripped = 1'b0;
      case (op)
         OP_TICK: begin
            if (uptime < UPTIME_SAT) uptime++;
            if (uptime > blank_len && sense > trip_level) begin
               halt_drive();
               powered = 1'b0;
               tripped = 1'b1;
            end
            ramp_count = (ramp_count + 1) % 256;
            if (ramp_count >= ramp_len) begin
               ramp_count = 0;
               if (powered && speed_now != speed_goal) begin
                  speed_now += (speed_now > speed_goal) ? -1 : 1;
                  relay = (speed_now < 0) ? 1'b0 : 1'b1;
                  dac = (magnitude_of(speed_now) > 255) ? 255 : magnitude_of(speed_now);
                  n_ramps++;
               end
            end
         end
         OP_SET_TARGET: begin
            if (powered && req <= SPEED_LIMIT && req >= -SPEED_LIMIT) speed_goal = req;
            else refused = 1'b1;
         end
         OP_REVERSE: begin
            relay = !rev;
            if (rev) begin
               speed_now = -magnitude_of(speed_now);
               speed_goal = -magnitude_of(speed_goal);
            end else begin
               speed_now = magnitude_of(speed_now);
               speed_goal = magnitude_of(speed_goal);
            end
         end
         OP_STOP: halt_drive();
         OP_CLEAR_FAULT: powered = 1'b1;
         default: ;
      endcase
      n_trips += tripped;
      n_rejects += refused;
      return drive_result(dac, relay, speed_now, speed_goal, powered, refused, tripped);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RESULT_W-1:0];
         if (expected_drive.size() == 0) begin
            fail_count++;
            $error("result transaction with no expectation pending: %h", rsp_tdata);
         end else begin
            want = expected_drive.pop_front();
            n_results++;
            check_field("dac_level", want.dac_level, got.dac_level);
            check_field("relay_drive", want.relay_drive, got.relay_drive);
            check_field("actual_speed", want.actual_speed, got.actual_speed);
            check_field("target_speed", want.target_speed, got.target_speed);
            check_field("enabled", want.enabled, got.enabled);
            check_field("command_rejected", want.command_rejected, got.command_rejected);
            check_field("fault_tripped", want.fault_tripped, got.fault_tripped);
            check_field("zero_fill", 0, rsp_tdata[31:RESULT_W]);
         end
      end
   end

   task automatic send_req(input logic [2:0] op, input logic signed [REQ_SPEED_W-1:0] speed,
         input logic rev, input logic [11:0] sense, input bit typed, input result_type drive);
      result_type predicted;
      if (csr_held) begin
         csr_valid <= 1'b0;
         csr_held = 1'b0;
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'({sense, rev, speed});
      req_held = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_drive_result(op, speed, rev, sense);
      expected_drive.push_back(typed ? drive : predicted);
      n_items++;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   task automatic drain();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      while (expected_drive.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [BLANK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      csr_held = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TRIP_THRESHOLD: trip_level = value[THRESH_W-1:0];
         CSR_BLANKING_TICKS: blank_len = value;
         CSR_RAMP_PERIOD: ramp_len = value[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_random_item();
      int pick;
      logic [2:0] op;
      logic signed [REQ_SPEED_W-1:0] speed;
      logic rev;
      logic [11:0] sense;
      pick = $urandom_range(0, 99);
      speed = $urandom;
      rev = $urandom;
      sense = $urandom;
      if (pick < 55) begin
         op = OP_TICK;
         if ($urandom_range(0, 9) != 0) sense = $urandom_range(0, trip_level);
      end else if (pick < 75) begin
         op = OP_SET_TARGET;
         if ($urandom_range(0, 4) != 0)
            speed = int'($urandom_range(0, 2 * SPEED_LIMIT)) - SPEED_LIMIT;
      end else if (pick < 83) begin
         op = OP_REVERSE;
      end else if (pick < 88) begin
         op = OP_STOP;
      end else if (pick < 96) begin
         op = OP_CLEAR_FAULT;
      end else begin
         op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
      end
      send_req(op, speed, rev, sense, 1'b0, '0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input int thresh,
         input int blank, input int period, input int count);
      drain();
      write_csr(CSR_TRIP_THRESHOLD, thresh);
      write_csr(CSR_BLANKING_TICKS, blank);
      write_csr(CSR_RAMP_PERIOD, period);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (count) send_random_item();
   endtask

   initial begin
      trip_level = THRESH_RESET;
      blank_len = BLANK_RESET;
      ramp_len = PERIOD_RESET;
      speed_now = 0;
      speed_goal = 0;
      dac = 0;
      relay = 1'b1;
      powered = 1'b1;
      uptime = 0;
      ramp_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;

      // Reset defaults, range limits on set target, reverse, spare opcodes and stop.
      script.push_back(item_row(OP_TICK, 0, 0, 0, 1, drive_result(0, 1, 0, 0, 1, 0, 0)));
      script.push_back(item_row(OP_TICK, -1024, 1, 4095, 1, drive_result(0, 1, 0, 0, 1, 0, 0)));
      script.push_back(item_row(OP_SET_TARGET, 255, 0, 0, 1, drive_result(0, 1, 0, 255, 1, 0, 0)));
      script.push_back(item_row(OP_SET_TARGET, 256, 0, 0, 1, drive_result(0, 1, 0, 255, 1, 1, 0)));
      script.push_back(item_row(OP_SET_TARGET, -255, 1, 0, 1,
         drive_result(0, 1, 0, -255, 1, 0, 0)));
      script.push_back(item_row(OP_SET_TARGET, -256, 0, 0, 1,
         drive_result(0, 1, 0, -255, 1, 1, 0)));
      script.push_back(item_row(OP_SET_TARGET, -1024, 0, 4095, 1,
         drive_result(0, 1, 0, -255, 1, 1, 0)));
      script.push_back(item_row(OP_SET_TARGET, 1023, 1, 0, 1,
         drive_result(0, 1, 0, -255, 1, 1, 0)));
      script.push_back(item_row(OP_REVERSE, 0, 0, 0, 1, drive_result(0, 1, 0, 255, 1, 0, 0)));
      script.push_back(item_row(OP_REVERSE, 0, 1, 0, 1, drive_result(0, 0, 0, -255, 1, 0, 0)));
      script.push_back(item_row(OP_SPARE_LO, 100, 0, 0, 1, drive_result(0, 0, 0, -255, 1, 0, 0)));
      script.push_back(item_row(OP_SPARE_HI, 1023, 1, 4095, 1,
         drive_result(0, 0, 0, -255, 1, 0, 0)));
      script.push_back(item_row(OP_STOP, 0, 0, 0, 1, drive_result(0, 1, 0, 0, 1, 0, 0)));
      // Ramping, threshold boundary, trip, and commands on a disabled supply.
      script.push_back(csr_row(CSR_RAMP_PERIOD, 1));
      script.push_back(csr_row(CSR_BLANKING_TICKS, 0));
      script.push_back(item_row(OP_SET_TARGET, -2, 0, 0, 0, '0));
      script.push_back(item_row(OP_TICK, 0, 0, 0, 0, '0));
      script.push_back(item_row(OP_TICK, 0, 0, 1000, 0, '0));
      script.push_back(item_row(OP_TICK, 0, 0, 1001, 1, drive_result(0, 1, 0, 0, 0, 0, 1)));
      script.push_back(item_row(OP_SET_TARGET, 5, 0, 0, 1, drive_result(0, 1, 0, 0, 0, 1, 0)));
      script.push_back(item_row(OP_REVERSE, 0, 1, 0, 1, drive_result(0, 0, 0, 0, 0, 0, 0)));
      script.push_back(item_row(OP_CLEAR_FAULT, 0, 0, 0, 1, drive_result(0, 0, 0, 0, 1, 0, 0)));
      script.push_back(csr_row(CSR_TRIP_THRESHOLD, 4095));
      script.push_back(item_row(OP_TICK, 0, 0, 4095, 0, '0));
      script.push_back(csr_row(CSR_TRIP_THRESHOLD, 0));
      script.push_back(item_row(OP_TICK, 0, 0, 0, 0, '0));
      script.push_back(item_row(OP_TICK, 0, 0, 1, 1, drive_result(0, 1, 0, 0, 0, 0, 1)));
      script.push_back(item_row(OP_CLEAR_FAULT, 0, 0, 0, 0, '0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            drain();
            write_csr(script[i].reg_index, script[i].reg_value);
         end else begin
            send_req(script[i].op, script[i].speed, script[i].rev, script[i].sense,
               script[i].typed, script[i].drive);
         end
      end

      run_phase(0, 0, 4095, 0, 1, 200);
      run_phase(88, 0, 0, 65535, 255, 200);
      run_phase(0, 88, $urandom_range(500, 3500), $urandom_range(0, 300),
         $urandom_range(1, 4), 200);
      run_phase(26, 26, 2048, 0, 3, 200);
      run_phase(0, 0, $urandom_range(0, 4095), $urandom_range(0, 1500), $urandom_range(1, 8),
         200);
      run_phase(88, 0, $urandom_range(0, 4095), $urandom_range(0, 1500), $urandom_range(1, 255),
         200);
      run_phase(0, 88, $urandom_range(0, 4095), $urandom_range(0, 65535), $urandom_range(1, 8),
         200);
      run_phase(26, 26, 3000, 200, 1, 200);

      // Blanking at the top of its range with the lowest threshold.
      run_phase(26, 26, 0, 65534, 1, 60);
      run_phase(26, 26, 0, 65535, 3, 40);

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d request transactions and checked %0d results over ten configurations.",
         n_items, n_results);
      $display("Saw %0d trips, %0d rejected targets and %0d ramp steps.",
         n_trips, n_rejects, n_ramps);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
